>>> sv/cert_pkg.sv
// ----------------------------------------------------------------------------
// cert_pkg
// Shared types, codes and decode helpers for the CAN receive error tracker.
// ----------------------------------------------------------------------------
package cert_pkg;

	localparam int EVENT_DEPTH = 16;
	localparam int RING_AW     = $clog2(EVENT_DEPTH);
	localparam int NUM_CNT     = 5;
	localparam int CNT_AW      = $clog2(NUM_CNT);

	localparam logic [1:0] OP_FRAME = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CNT   = 2'd2;

	localparam logic [2:0] RK_DATA    = 3'd0;
	localparam logic [2:0] RK_LOGGED  = 3'd1;
	localparam logic [2:0] RK_INVALID = 3'd2;
	localparam logic [2:0] RK_IOERR   = 3'd3;
	localparam logic [2:0] RK_EVENT   = 3'd4;
	localparam logic [2:0] RK_EMPTY   = 3'd5;
	localparam logic [2:0] RK_COUNTER = 3'd6;

	localparam logic [3:0] EK_UNKNOWN    = 4'd0;
	localparam logic [3:0] EK_BUSOFF     = 4'd1;
	localparam logic [3:0] EK_RESTARTED  = 4'd2;
	localparam logic [3:0] EK_PASSIVE    = 4'd3;
	localparam logic [3:0] EK_WARNING    = 4'd4;
	localparam logic [3:0] EK_OVERFLOW   = 4'd5;
	localparam logic [3:0] EK_ARBLOST    = 4'd6;
	localparam logic [3:0] EK_PROTOCOL   = 4'd7;
	localparam logic [3:0] EK_CONTROLLER = 4'd8;

	localparam logic [2:0] BUS_UNKNOWN = 3'd0;
	localparam logic [2:0] BUS_ACTIVE  = 3'd1;
	localparam logic [2:0] BUS_WARNING = 3'd2;
	localparam logic [2:0] BUS_PASSIVE = 3'd3;
	localparam logic [2:0] BUS_OFF     = 3'd4;

	localparam logic [2:0] CNT_RX_FRAMES = 3'd0;
	localparam logic [2:0] CNT_RX_ERRORS = 3'd1;
	localparam logic [2:0] CNT_ERR_FRAMES = 3'd2;
	localparam logic [2:0] CNT_OVERRUNS  = 3'd3;
	localparam logic [2:0] CNT_DROPS     = 3'd4;

	localparam logic [28:0] CL_TXTIMEOUT = 29'h001;
	localparam logic [28:0] CL_LOSTARB   = 29'h002;
	localparam logic [28:0] CL_CRTL      = 29'h004;
	localparam logic [28:0] CL_PROT      = 29'h008;
	localparam logic [28:0] CL_TRX       = 29'h010;
	localparam logic [28:0] CL_BUSOFF    = 29'h040;
	localparam logic [28:0] CL_RESTARTED = 29'h100;

	localparam logic [7:0] D1_RX_OVF  = 8'h01;
	localparam logic [7:0] D1_WARN    = 8'h0C;
	localparam logic [7:0] D1_PASSIVE = 8'h30;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] raw_id_word;
		logic [7:0]  raw_length;
		logic [63:0] raw_payload;
		logic        io_failed;
		logic [31:0] arrival_time;
		logic [2:0]  counter_select;
	} rx_word_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [28:0] frame_id;
		logic        is_extended;
		logic        is_remote;
		logic [3:0]  frame_length;
		logic [63:0] frame_payload;
		logic [3:0]  event_kind;
		logic [28:0] event_flags;
		logic [31:0] stamp;
		logic [2:0]  bus_condition;
		logic [31:0] counter_value;
	} res_word_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [28:0] flags;
		logic [31:0] stamp;
	} event_entry_t;

	localparam int ENTRY_W = $bits(event_entry_t);

	function automatic logic [3:0] classify(input logic [28:0] flags, input logic [7:0] d1);
		logic crtl;
		crtl = |(flags & CL_CRTL);
		priority if (|(flags & CL_BUSOFF))            return EK_BUSOFF;
		else if (|(flags & CL_RESTARTED))             return EK_RESTARTED;
		else if (crtl && |(d1 & D1_PASSIVE))          return EK_PASSIVE;
		else if (crtl && |(d1 & D1_WARN))             return EK_WARNING;
		else if (crtl && |(d1 & D1_RX_OVF))           return EK_OVERFLOW;
		else if (|(flags & CL_LOSTARB))               return EK_ARBLOST;
		else if (|(flags & CL_PROT))                  return EK_PROTOCOL;
		else if (|(flags & (CL_CRTL | CL_TRX | CL_TXTIMEOUT))) return EK_CONTROLLER;
		else                                          return EK_UNKNOWN;
	endfunction

	function automatic logic [2:0] next_bus(input logic [2:0] mode, input logic [3:0] kind);
		logic [2:0] nxt;
		nxt = mode;
		if (kind == EK_BUSOFF)         nxt = BUS_OFF;
		else if (kind == EK_RESTARTED) nxt = BUS_ACTIVE;
		else if (kind == EK_PASSIVE)   nxt = BUS_PASSIVE;
		else if (kind == EK_WARNING)   nxt = BUS_WARNING;
		return nxt;
	endfunction

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
		if (idx == RING_AW'(EVENT_DEPTH - 1)) return '0;
		else return idx + RING_AW'(1);
	endfunction

	function automatic logic [63:0] payload_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < len) m[8*i +: 8] = 8'hFF;
		end
		return m;
	endfunction

endpackage

>>> sv/can_rx_error_event_tracker.sv
// ----------------------------------------------------------------------------
// can_rx_error_event_tracker
// Decodes received SocketCAN words, logs error events into a ring, and
// serves event pops and statistics counter reads.
// ----------------------------------------------------------------------------
// One word per clock sustained while res_stall is low; each word's result
// passes stage register res_s1, then output register res_q. Error events sit
// in a 16-entry RAM ring (one slot kept empty); a pop reads the tail entry
// through the RAM's registered read port, feeding the word leaving res_s1.
// The bus condition, ring pointers and the five wrapping 32-bit counters
// update at acceptance, so the next word sees them at once. Opcode 3 is
// accepted and gives no result. The event RAM needs no clearing after reset.
module can_rx_error_event_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  cert_pkg::rx_word_t  rx_word,
	output logic                res_valid,
	input  logic                res_stall,
	output cert_pkg::res_word_t res_word
);

	import cert_pkg::*;

	logic [2:0]         bus_q;
	logic [31:0]        cnt_q [NUM_CNT];
	logic [RING_AW-1:0] head_q, tail_q;

	logic               valid_s1, pop_s1;
	res_word_t          res_s1;
	logic               res_valid_q;
	res_word_t          res_q;
	res_word_t          res_out;

	logic               fire, s1_adv;
	logic               push_en, pop_en, emit;
	logic [NUM_CNT-1:0] cnt_inc;
	logic [2:0]         bus_d;
	res_word_t          res_d;
	event_entry_t       wr_entry, rd_entry;
	logic [ENTRY_W-1:0] rd_data;

	logic [28:0] flags;
	logic [7:0]  d1;
	logic [3:0]  kind;
	logic        ext;
	logic        ring_full, ring_empty;

	assign s1_adv   = !res_valid_q || !res_stall;
	assign rx_stall = valid_s1 && !s1_adv;
	assign fire     = rx_valid && !rx_stall;

	assign flags      = rx_word.raw_id_word[28:0];
	assign d1         = rx_word.raw_payload[15:8];
	assign kind       = classify(flags, d1);
	assign ext        = rx_word.raw_id_word[31];
	assign ring_full  = ring_next(head_q) == tail_q;
	assign ring_empty = head_q == tail_q;

	assign wr_entry = '{kind: kind, flags: flags, stamp: rx_word.arrival_time};

	always_comb begin
		res_d   = '0;
		cnt_inc = '0;
		push_en = 1'b0;
		pop_en  = 1'b0;
		emit    = 1'b1;
		bus_d   = bus_q;
		unique case (rx_word.opcode)
			OP_FRAME: begin
				priority if (rx_word.io_failed) begin
					cnt_inc[CNT_RX_ERRORS] = 1'b1;
					res_d.result_kind      = RK_IOERR;
				end else if (rx_word.raw_id_word[29]) begin
					cnt_inc[CNT_ERR_FRAMES] = 1'b1;
					cnt_inc[CNT_OVERRUNS]   = |(flags & CL_CRTL) && |(d1 & D1_RX_OVF);
					cnt_inc[CNT_DROPS]      = ring_full;
					push_en                 = !ring_full;
					bus_d                   = next_bus(bus_q, kind);
					res_d.result_kind       = RK_LOGGED;
					res_d.event_kind        = kind;
					res_d.event_flags       = flags;
					res_d.stamp             = rx_word.arrival_time;
				end else if (rx_word.raw_length > 8'd8) begin
					cnt_inc[CNT_RX_ERRORS] = 1'b1;
					res_d.result_kind      = RK_INVALID;
				end else begin
					cnt_inc[CNT_RX_FRAMES] = 1'b1;
					res_d.result_kind      = RK_DATA;
					res_d.frame_id         = ext ? flags : {18'd0, flags[10:0]};
					res_d.is_extended      = ext;
					res_d.is_remote        = rx_word.raw_id_word[30];
					res_d.frame_length     = rx_word.raw_length[3:0];
					res_d.frame_payload    = rx_word.raw_payload
						& payload_mask(rx_word.raw_length[3:0]);
					res_d.stamp            = rx_word.arrival_time;
				end
			end
			OP_POP: begin
				pop_en            = !ring_empty;
				res_d.result_kind = ring_empty ? RK_EMPTY : RK_EVENT;
			end
			OP_CNT: begin
				res_d.result_kind = RK_COUNTER;
				if (rx_word.counter_select < 3'(NUM_CNT))
					res_d.counter_value = cnt_q[rx_word.counter_select[CNT_AW-1:0]];
			end
			default: emit = 1'b0;
		endcase
		res_d.bus_condition = bus_d;
	end

	cert_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (EVENT_DEPTH)
	) u_event_ram (
		.clk     (clk),
		.wr_en   (fire && push_en),
		.wr_addr (head_q),
		.wr_data (wr_entry),
		.rd_en   (fire && pop_en),
		.rd_addr (tail_q),
		.rd_data (rd_data)
	);

	assign rd_entry = event_entry_t'(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q  <= BUS_UNKNOWN;
			head_q <= '0;
			tail_q <= '0;
			for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
		end else if (fire) begin
			bus_q <= bus_d;
			if (push_en) head_q <= ring_next(head_q);
			if (pop_en)  tail_q <= ring_next(tail_q);
			for (int i = 0; i < NUM_CNT; i++) begin
				if (cnt_inc[i]) cnt_q[i] <= cnt_q[i] + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire)        valid_s1 <= emit;
			else if (s1_adv) valid_s1 <= 1'b0;
			if (s1_adv)      res_valid_q <= valid_s1;
		end
	end

	always_comb begin
		res_out = res_s1;
		if (pop_s1) begin
			res_out.event_kind  = rd_entry.kind;
			res_out.event_flags = rd_entry.flags;
			res_out.stamp       = rd_entry.stamp;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res_d;
			pop_s1 <= pop_en;
		end
		if (s1_adv && valid_s1) res_q <= res_out;
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with no held word");

	a_s1_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && s1_adv |=> res_valid_q)
		else $error("stage word lost on advance");

	a_pop_moves_tail: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_en |=> tail_q != $past(tail_q) && head_q == $past(head_q))
		else $error("pop did not advance tail alone");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && push_en |=> head_q != tail_q)
		else $error("ring overrun");

	a_bus_range: assert property (@(posedge clk) disable iff (!arst_n)
		bus_q <= BUS_OFF)
		else $error("bus condition out of range");

endmodule

>>> sv/cert_ram.sv
// ----------------------------------------------------------------------------
// cert_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cert_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem_q[rd_addr];
	end

endmodule
